### rtl/fpau_pkg.sv
// shared types and constants for the fixed-point arithmetic unit
package fpau_pkg;

  typedef enum logic [1:0] {
    MODE_MUL   = 2'd0,
    MODE_DIV   = 2'd1,
    MODE_F2FIX = 2'd2,
    MODE_ABS   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam int unsigned DIV_BPS       = 4;   // quotient bits per divider stage

  localparam logic [23:0] MANT_HIDDEN = 24'h800000;
  localparam logic [22:0] MANT_MASK   = 23'h7fffff;
  localparam logic [7:0]  EXP_MASK    = 8'hff;
  localparam int          EXP_BIAS    = 127;
  localparam int          MANT_BITS   = 23;

  localparam logic [31:0] DIV0_RESULT = 32'h7fffffff;

endpackage

### rtl/fixed_point_arith_unit.sv
// signed fixed-point alu: multiply, divide, float-to-fixed, absolute value
//
//  channel  signals                                    direction
//  in       in_valid in_ready in_mode in_operand_a/b   request in
//  out      out_valid out_ready out_result out_status  request out
//
// one request enters per cycle while the output is not stalled; the pipeline depth is
// set by the restoring divider stages, DIV_BPS quotient bits a stage
// all modes ride the same pipeline so results leave in request order
// rst_n clears only the valid bits; payload registers are not reset
// a stalled output holds the whole pipeline, in_ready follows out_ready then
module fixed_point_arith_unit #(
  parameter int unsigned FRAC_BITS = fpau_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic signed [31:0]   in_operand_a,
  input  logic signed [31:0]   in_operand_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_result,
  output logic [1:0]           out_status
);
  import fpau_pkg::*;

  localparam int unsigned NW      = 32 + FRAC_BITS;
  localparam int unsigned DIV_STG = (NW + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned NP      = DIV_STG * DIV_BPS;

  logic ce;

  // pipeline registers, index 0 is the input stage
  logic              p_v_r    [DIV_STG+1];
  mode_t             p_mode_r [DIV_STG+1];
  logic [31:0]       p_res_r  [DIV_STG+1];
  logic [31:0]       p_rem_r  [DIV_STG+1];
  logic [NP-1:0]     p_num_r  [DIV_STG+1];
  logic [31:0]       p_div_r  [DIV_STG+1];
  logic              p_neg_r  [DIV_STG+1];
  logic              p_dz_r   [DIV_STG+1];

  logic              p_v_nxt    [DIV_STG+1];
  mode_t             p_mode_nxt [DIV_STG+1];
  logic [31:0]       p_res_nxt  [DIV_STG+1];
  logic [31:0]       p_rem_nxt  [DIV_STG+1];
  logic [NP-1:0]     p_num_nxt  [DIV_STG+1];
  logic [31:0]       p_div_nxt  [DIV_STG+1];
  logic              p_neg_nxt  [DIV_STG+1];
  logic              p_dz_nxt   [DIV_STG+1];

  logic signed [31:0] mul_a_r, mul_b_r;
  logic signed [63:0] prod_r, prod_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_result_r, out_result_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  assign ce       = !out_valid_r || out_ready;
  assign in_ready = ce;

  // input stage: magnitudes, signs, float conversion and abs
  always_comb begin
    logic [31:0]       ma, mb, fv, mant;
    logic [7:0]        expo;
    logic signed [9:0] sh, ls;
    ma   = in_operand_a[31] ? 32'(-in_operand_a) : in_operand_a;
    mb   = in_operand_b[31] ? 32'(-in_operand_b) : in_operand_b;
    expo = in_operand_a[30:23] & EXP_MASK;
    mant = {8'd0, ({1'b0, in_operand_a[22:0] & MANT_MASK} | MANT_HIDDEN)};
    sh   = 10'(EXP_BIAS + MANT_BITS - int'(FRAC_BITS)) - $signed({2'b00, expo});
    ls   = -sh;
    if (sh > 0) begin
      fv = (sh >= 10'sd32) ? 32'd0 : (mant >> sh[4:0]);
    end else begin
      fv = (ls >= 10'sd32) ? 32'd0 : (mant << ls[4:0]);
    end
    if (in_operand_a[31]) begin
      fv = -fv;
    end
    p_v_nxt[0]    = in_valid;
    p_mode_nxt[0] = mode_t'(in_mode);
    p_res_nxt[0]  = (in_mode == MODE_F2FIX) ? fv : ma;
    p_rem_nxt[0]  = '0;
    p_num_nxt[0]  = NP'({ma, {FRAC_BITS{1'b0}}});
    p_div_nxt[0]  = mb;
    p_neg_nxt[0]  = (in_operand_a > 0 && in_operand_b < 0) ||
                    (in_operand_a < 0 && in_operand_b > 0);
    p_dz_nxt[0]   = (in_operand_b == 32'sd0);
  end

  assign prod_nxt = mul_a_r * mul_b_r;

  // divider stages, DIV_BPS restoring steps each
  for (genvar k = 1; k <= DIV_STG; k++) begin : g_stg
    always_comb begin
      logic [32:0]   t;
      logic [31:0]   rm;
      logic [NP-1:0] nm;
      logic [63:0]   psh;
      rm  = p_rem_r[k-1];
      nm  = p_num_r[k-1];
      psh = 64'(prod_r >>> FRAC_BITS);
      for (int i = 0; i < DIV_BPS; i++) begin
        t = {rm, nm[NP-1]};
        if (t >= {1'b0, p_div_r[k-1]}) begin
          rm = 32'(t - {1'b0, p_div_r[k-1]});
          nm = {nm[NP-2:0], 1'b1};
        end else begin
          rm = t[31:0];
          nm = {nm[NP-2:0], 1'b0};
        end
      end
      p_v_nxt[k]    = p_v_r[k-1];
      p_mode_nxt[k] = p_mode_r[k-1];
      p_res_nxt[k]  = p_res_r[k-1];
      if (k == 2 && p_mode_r[k-1] == MODE_MUL) begin
        // product was registered one stage earlier
        p_res_nxt[k] = psh[31:0];
      end
      p_rem_nxt[k]  = rm;
      p_num_nxt[k]  = nm;
      p_div_nxt[k]  = p_div_r[k-1];
      p_neg_nxt[k]  = p_neg_r[k-1];
      p_dz_nxt[k]   = p_dz_r[k-1];
    end
  end

  // output stage: quotient sign and status
  always_comb begin
    logic [NP-1:0] q, qs;
    q  = p_num_r[DIV_STG];
    qs = p_neg_r[DIV_STG] ? -q : q;
    out_valid_nxt  = p_v_r[DIV_STG];
    out_result_nxt = p_res_r[DIV_STG];
    out_status_nxt = ST_OK;
    if (p_mode_r[DIV_STG] == MODE_DIV) begin
      if (p_dz_r[DIV_STG]) begin
        out_result_nxt = DIV0_RESULT;
        out_status_nxt = ST_DIV0;
      end else begin
        out_result_nxt = qs[31:0];
        out_status_nxt = (|q[NP-1:31]) ? ST_OVF : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STG; k++) begin
        p_v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (ce) begin
      for (int k = 0; k <= DIV_STG; k++) begin
        p_v_r[k] <= p_v_nxt[k];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k <= DIV_STG; k++) begin
        p_mode_r[k] <= p_mode_nxt[k];
        p_res_r[k]  <= p_res_nxt[k];
        p_rem_r[k]  <= p_rem_nxt[k];
        p_num_r[k]  <= p_num_nxt[k];
        p_div_r[k]  <= p_div_nxt[k];
        p_neg_r[k]  <= p_neg_nxt[k];
        p_dz_r[k]   <= p_dz_nxt[k];
      end
      mul_a_r      <= in_operand_a;
      mul_b_r      <= in_operand_b;
      prod_r       <= prod_nxt;
      out_result_r <= out_result_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

`ifndef SYNTH
  a_div0_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV0 |-> out_result == DIV0_RESULT)
    else $error("divide by zero result wrong");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_NONE)
    else $error("unused status code");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r[DIV_STG] && !ce |=> p_v_r[DIV_STG])
    else $error("request dropped from last stage during stall");

  a_nonmul_status: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r[DIV_STG] && p_mode_r[DIV_STG] != MODE_DIV && ce |=> out_status == ST_OK)
    else $error("status set outside divide");
`endif

endmodule
